>>> design/dwdm_pkg.sv
// Shared operation and status codes for the double-ended queue with delete.
package dwdm_pkg;

   // Operation codes carried on the request mode field.
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
   localparam logic [2:0] MODE_POP_BACK   = 3'd1;
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd2;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [2:0] MODE_DELETE     = 3'd4;

   // Status codes returned with every response.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd3;

endpackage

>>> design/dwdm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dwdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/deque_with_delete_match_unit.sv
// Top level: double-ended queue in a ring RAM with a delete-first-match sequencer.
// Push, unused mode, push on full, or pop or delete on an empty queue: response registered
// from the request. Pop: from the ring RAM's registered read. Delete on a non-empty queue:
// entries compared from the head to the first match, later ones then moved down to close the
// gap unless it is the head. A new request is taken the cycle after its result is accepted.
// Reset is synchronous; it empties the queue and clears the head; RAM is not cleared.
module deque_with_delete_match_unit
   import dwdm_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_mode,
   input  logic [31:0]                  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [31:0]                  rsp_popped,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_entry_count,
   output logic [1:0]                   rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [AW-1:0]         k_ff, k_in;
   logic [AW-1:0]         cur_ff, cur_in;
   logic [AW-1:0]         nxt_ff, nxt_in;
   logic [DATA_WIDTH-1:0] match_ff, match_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_popped_ff, rsp_popped_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic                  ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;

   logic [DATA_WIDTH-1:0] req_data;
   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  hit;
   logic                  more_after_k;
   logic                  more_after_k1;

   // Ring position of logical entry pos, counted from the head.
   function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] head,
                                               input logic [CW-1:0] pos);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(pos);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // Next ring position with wrap.
   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] s);
      logic [AW-1:0] r;
      if (s == AW'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = s + AW'(1);
      end
      return r;
   endfunction

   dwdm_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign req_data  = DATA_WIDTH'(req_value);
   assign full      = (occ_ff == CW'(DEPTH));
   assign empty     = (occ_ff == '0);

   // The one shared compare unit and the walk bounds of the delete sequencer.
   assign hit           = (ram_rdata == match_ff);
   assign more_after_k  = (SW'(k_ff) + SW'(1)) < SW'(occ_ff);
   assign more_after_k1 = (SW'(k_ff) + SW'(2)) < SW'(occ_ff);

   // Sequencer next-state logic and RAM control.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      k_in          = k_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      match_in      = match_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_popped_in = rsp_popped_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = cur_ff;
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = nxt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_popped_in = '0;
               rsp_status_in = STATUS_OK;
               rsp_valid_in  = 1'b1;
               unique case (req_mode)
                  MODE_PUSH_BACK: begin
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ring_slot(head_ff, occ_ff);
                        ram_wdata = req_data;
                        occ_in    = occ_ff + CW'(1);
                     end
                  end
                  MODE_PUSH_FRONT: begin
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        head_in   = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
                        ram_we    = 1'b1;
                        ram_waddr = head_in;
                        ram_wdata = req_data;
                        occ_in    = occ_ff + CW'(1);
                     end
                  end
                  MODE_POP_BACK: begin
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        occ_in       = occ_ff - CW'(1);
                        ram_re       = 1'b1;
                        ram_raddr    = ring_slot(head_ff, occ_in);
                        rsp_valid_in = 1'b0;
                        state_in     = ST_POP_RD;
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        occ_in       = occ_ff - CW'(1);
                        ram_re       = 1'b1;
                        ram_raddr    = head_ff;
                        head_in      = ring_inc(head_ff);
                        rsp_valid_in = 1'b0;
                        state_in     = ST_POP_RD;
                     end
                  end
                  MODE_DELETE: begin
                     if (empty) begin
                        rsp_status_in = STATUS_NO_MATCH;
                     end else begin
                        match_in     = req_data;
                        k_in         = '0;
                        cur_in       = head_ff;
                        ram_re       = 1'b1;
                        ram_raddr    = head_ff;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = occ_in;
            end
         end

         ST_POP_RD: begin
            // Read data for the popped entry arrives in the cycle after the read is issued.
            rsp_popped_in = 32'(ram_rdata);
            rsp_count_in  = occ_ff;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_SCAN: begin
            // Compare entry k against the match value.
            if (hit) begin
               if (k_ff == '0) begin
                  head_in      = ring_inc(head_ff);
                  occ_in       = occ_ff - CW'(1);
                  rsp_count_in = occ_in;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else if (more_after_k) begin
                  nxt_in    = ring_inc(cur_ff);
                  ram_re    = 1'b1;
                  ram_raddr = nxt_in;
                  state_in  = ST_SHIFT;
               end else begin
                  occ_in       = occ_ff - CW'(1);
                  rsp_count_in = occ_in;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (more_after_k) begin
               k_in      = k_ff + AW'(1);
               cur_in    = ring_inc(cur_ff);
               ram_re    = 1'b1;
               ram_raddr = cur_in;
            end else begin
               rsp_status_in = STATUS_NO_MATCH;
               rsp_count_in  = occ_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_SHIFT: begin
            // Move entry k+1 down into slot k, and fetch entry k+2 if it exists.
            ram_we    = 1'b1;
            ram_waddr = cur_ff;
            ram_wdata = ram_rdata;
            k_in      = k_ff + AW'(1);
            cur_in    = nxt_ff;
            nxt_in    = ring_inc(nxt_ff);
            if (more_after_k1) begin
               ram_re    = 1'b1;
               ram_raddr = nxt_in;
            end else begin
               occ_in       = occ_ff - CW'(1);
               rsp_count_in = occ_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      match_ff      <= match_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_popped      = rsp_popped_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
